### rtl/core/personal_id_code_checker_defines.svh
// assertion macros for the personal id code checker
`ifndef PERSONAL_ID_CODE_CHECKER_DEFINES_SVH
`define PERSONAL_ID_CODE_CHECKER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define PIDC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pidc assertion failed");

// consequent must hold in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidc assertion failed");

`endif

### rtl/core/pidc_pkg.sv
// types, constants and helper functions for the personal id code checker
package pidc_pkg;

  typedef logic [2:0] fail_code_t;
  typedef logic [3:0] digit_t;
  typedef logic [6:0] pair_t;

  localparam fail_code_t FAIL_OK       = 3'd0;
  localparam fail_code_t FAIL_LENGTH   = 3'd1;
  localparam fail_code_t FAIL_NONDIGIT = 3'd2;
  localparam fail_code_t FAIL_CENTURY  = 3'd3;
  localparam fail_code_t FAIL_RANGE    = 3'd4;
  localparam fail_code_t FAIL_DATE     = 3'd5;
  localparam fail_code_t FAIL_CHECK    = 3'd6;

  localparam logic [3:0] CODE_LEN = 4'd13;
  localparam logic [3:0] SUM_LEN  = 4'd12;
  localparam logic [3:0] POS_MAX  = 4'd15;
  localparam logic [3:0] MOD_BASE = 4'd11;

  localparam logic [3:0] POS_CENTURY = 4'd0;
  localparam logic [3:0] POS_YEAR_HI = 4'd1;
  localparam logic [3:0] POS_YEAR_LO = 4'd2;
  localparam logic [3:0] POS_MON_HI  = 4'd3;
  localparam logic [3:0] POS_MON_LO  = 4'd4;
  localparam logic [3:0] POS_DAY_HI  = 4'd5;
  localparam logic [3:0] POS_DAY_LO  = 4'd6;
  localparam logic [3:0] POS_CHECK   = 4'd12;

  // weight of each of the first twelve digits
  function automatic logic [3:0] digit_weight(input logic [3:0] pos);
    logic [3:0] w;
    case (pos)
      4'd0:    w = 4'd2;
      4'd1:    w = 4'd7;
      4'd2:    w = 4'd9;
      4'd3:    w = 4'd1;
      4'd4:    w = 4'd4;
      4'd5:    w = 4'd6;
      4'd6:    w = 4'd3;
      4'd7:    w = 4'd5;
      4'd8:    w = 4'd8;
      4'd9:    w = 4'd2;
      4'd10:   w = 4'd7;
      4'd11:   w = 4'd9;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // reduce a value below 96 modulo 11 by stepped subtraction
  function automatic logic [3:0] mod11(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (r >= 7'd88) r = r - 7'd88;
    if (r >= 7'd44) r = r - 7'd44;
    if (r >= 7'd22) r = r - 7'd22;
    if (r >= 7'(MOD_BASE)) r = r - 7'(MOD_BASE);
    return r[3:0];
  endfunction

  // month length, month already known to be 1..12
  function automatic logic [4:0] month_days(input pair_t month, input logic leap);
    logic [4:0] n;
    case (month)
      7'd2:                     n = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/personal_id_code_checker.sv
// personal id code checker: streaming length, digit, date and mod-11 check of a 13-digit code
// One ASCII word is taken per clock cycle while byte_stall is low; the word flagged with
// final_byte gives exactly one result (valid_res, failure) and the others give none. A word
// waits in the input register, where the running digit state is updated and, on a final word,
// the whole code is judged in one pass into the result register, so res_valid rises in the
// cycle after the final word leaves the input register. Throughput is one word per cycle
// while byte_stall is low; byte_stall rises only while a final word waits in the input register
// behind a result that res_stall holds. Failure codes: 0 ok, 1 length, 2 non-digit, 3 century
// digit, 4 month or day out of range, 5 no such date, 6 check digit. Strings longer than 15
// words still report a length failure.
`include "personal_id_code_checker_defines.svh"

module personal_id_code_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  logic [7:0]            character,
  input  logic                  final_byte,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  valid_res,
  output pidc_pkg::fail_code_t  failure
);
  import pidc_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] in_char;
  logic       in_final;
  logic       in_go;

  // running state of the current string
  logic       position_ok;
  logic [3:0] position, position_next;
  logic       saw_non_digit, saw_non_digit_next;
  digit_t     weighted_sum_mod, weighted_sum_mod_next;
  digit_t     century_digit, century_digit_next;
  pair_t      year_in_century, year_in_century_next;
  pair_t      month_value, month_value_next;
  pair_t      day_value, day_value_next;
  digit_t     check_digit_seen, check_digit_seen_next;

  logic       is_digit;
  digit_t     digit;
  pair_t      digit_tens;
  logic [7:0] product;
  logic       leap;
  digit_t     expect_digit;
  fail_code_t verdict;
  logic       out_free;

  assign out_free   = !res_valid || !res_stall;
  assign in_go      = in_full && (!in_final || out_free);
  assign byte_stall = in_full && !in_go;
  assign position_ok = (position != POS_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_char  <= character;
      in_final <= final_byte;
    end
  end

  // digit update for the word in the input register
  always_comb begin
    is_digit   = in_char inside {[8'h30:8'h39]};
    digit      = in_char[3:0];
    digit_tens = {3'd0, digit} * 7'd10;
    product    = {4'd0, digit} * {4'd0, digit_weight(position)};

    position_next         = position_ok ? position + 4'd1 : position;
    saw_non_digit_next    = saw_non_digit | !is_digit;
    weighted_sum_mod_next = weighted_sum_mod;
    century_digit_next    = century_digit;
    year_in_century_next  = year_in_century;
    month_value_next      = month_value;
    day_value_next        = day_value;
    check_digit_seen_next = check_digit_seen;

    if (is_digit) begin
      if (position < SUM_LEN) begin
        weighted_sum_mod_next = mod11({3'd0, weighted_sum_mod} + product[6:0]);
      end
      case (position)
        POS_CENTURY: century_digit_next    = digit;
        POS_YEAR_HI: year_in_century_next  = digit_tens;
        POS_YEAR_LO: year_in_century_next  = year_in_century + {3'd0, digit};
        POS_MON_HI:  month_value_next      = digit_tens;
        POS_MON_LO:  month_value_next      = month_value + {3'd0, digit};
        POS_DAY_HI:  day_value_next        = digit_tens;
        POS_DAY_LO:  day_value_next        = day_value + {3'd0, digit};
        POS_CHECK:   check_digit_seen_next = digit;
        default: ;
      endcase
    end
  end

  // judgment of the completed string
  always_comb begin
    // all century bases are multiples of four; year zero is a leap year only when the century digit is 5 or more
    leap = (year_in_century_next[1:0] == 2'd0) &&
           ((year_in_century_next != 7'd0) || (century_digit_next >= 4'd5));
    expect_digit = (weighted_sum_mod_next == 4'd10) ? 4'd1 : weighted_sum_mod_next;

    if (position_next != CODE_LEN) begin
      verdict = FAIL_LENGTH;
    end else if (saw_non_digit_next) begin
      verdict = FAIL_NONDIGIT;
    end else if (century_digit_next == 4'd0 || century_digit_next > 4'd9) begin
      verdict = FAIL_CENTURY;
    end else if (month_value_next < 7'd1 || month_value_next > 7'd12 ||
                 day_value_next < 7'd1 || day_value_next > 7'd31) begin
      verdict = FAIL_RANGE;
    end else if (day_value_next > {2'd0, month_days(month_value_next, leap)}) begin
      verdict = FAIL_DATE;
    end else if (expect_digit != check_digit_seen_next) begin
      verdict = FAIL_CHECK;
    end else begin
      verdict = FAIL_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_go && in_final)) begin
      position         <= 4'd0;
      saw_non_digit    <= 1'b0;
      weighted_sum_mod <= 4'd0;
      century_digit    <= 4'd0;
      year_in_century  <= 7'd0;
      month_value      <= 7'd0;
      day_value        <= 7'd0;
      check_digit_seen <= 4'd0;
    end else if (in_go) begin
      position         <= position_next;
      saw_non_digit    <= saw_non_digit_next;
      weighted_sum_mod <= weighted_sum_mod_next;
      century_digit    <= century_digit_next;
      year_in_century  <= year_in_century_next;
      month_value      <= month_value_next;
      day_value        <= day_value_next;
      check_digit_seen <= check_digit_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_go && in_final) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_final) begin
      failure   <= verdict;
      valid_res <= (verdict == FAIL_OK);
    end
  end

  `PIDC_ASSERT_ALWAYS(a_flag_matches_code, !res_valid || (valid_res == (failure == FAIL_OK)))
  `PIDC_ASSERT_ALWAYS(a_code_in_range, !res_valid || (failure <= FAIL_CHECK))
  `PIDC_ASSERT_NEXT(a_final_gives_result, in_go && in_final, res_valid)
  `PIDC_ASSERT_NEXT(a_clear_after_final, in_go && in_final, position == 4'd0)

endmodule
